// ===== design/gtg_pkg.sv =====
// Shared constants, types and tables of the go-to-goal controller.
package gtg_pkg;

  // Field widths
  localparam int PosW   = 16;
  localparam int DiffW  = 17;
  localparam int AngW   = 15;
  localparam int SpeedW = 16;
  localparam int GainW  = 16;
  localparam int ModeW  = 2;

  // Configuration port
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CfgTargetX  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgTargetY  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgGain     = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgMaxSpeed = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgDistThr  = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgAngThr   = 3'd5;

  localparam logic [PosW-1:0]   TargetXRst  = 16'd256;
  localparam logic [PosW-1:0]   TargetYRst  = 16'd256;
  localparam logic [GainW-1:0]  GainRst     = 16'd4096;
  localparam logic [SpeedW-1:0] MaxSpeedRst = 16'd768;
  localparam logic [SpeedW-1:0] DistThrRst  = 16'd26;
  localparam logic [AngW-1:0]   AngThrRst   = 15'd819;

  // Result modes
  localparam logic [ModeW-1:0] ModeStop    = 2'd0;
  localparam logic [ModeW-1:0] ModeRotate  = 2'd1;
  localparam logic [ModeW-1:0] ModeForward = 2'd2;

  // Datapath widths
  localparam int SqW       = 34;  // dx^2 + dy^2
  localparam int CxW       = 34;  // CORDIC x/y
  localparam int CzW       = 32;  // angle in 2^-28 rad
  localparam int DistW     = 17;
  localparam int SqrtSteps = 17;  // one result bit per step
  localparam int SqrtTop   = 32;  // exponent of the first trial bit
  localparam int PreShift  = 14;

  localparam int CordicStagesDef = 16;
  localparam int AtanEntries     = 24;

  // atan(2^-i) in units of 2^-28 rad
  localparam logic signed [CzW-1:0] AtanTab [AtanEntries] = '{
    32'sd210828714, 32'sd124459457, 32'sd65760959, 32'sd33381290,
    32'sd16755422,  32'sd8385879,   32'sd4193963,  32'sd2097109,
    32'sd1048571,   32'sd524287,    32'sd262144,   32'sd131072,
    32'sd65536,     32'sd32768,     32'sd16384,    32'sd8192,
    32'sd4096,      32'sd2048,      32'sd1024,     32'sd512,
    32'sd256,       32'sd128,       32'sd64,       32'sd32
  };

  localparam logic signed [CzW-1:0] AtanPiHalf = 32'sd421657428;

  // Payload of one square-root / CORDIC pipeline stage
  typedef struct packed {
    logic [SqW-1:0]         rem;
    logic [SqW-1:0]         root;
    logic signed [CxW-1:0]  cx;
    logic signed [CxW-1:0]  cy;
    logic signed [CzW-1:0]  cz;
    logic signed [AngW-1:0] hd;
  } gtg_stage_t;

endpackage

// ===== design/gtg_if.sv =====
// Pose and command stream interfaces of the go-to-goal controller.
interface gtg_pose_if;
  import gtg_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [PosW-1:0] pos_x;
  logic signed [PosW-1:0] pos_y;
  logic signed [AngW-1:0] heading;

  modport source (output valid, pos_x, pos_y, heading, input ready);
  modport sink   (input valid, pos_x, pos_y, heading, output ready);
endinterface

interface gtg_cmd_if;
  import gtg_pkg::*;
  logic              valid;
  logic              ready;
  logic [SpeedW-1:0] linear_speed;
  logic [AngW-1:0]   angular_speed;
  logic [ModeW-1:0]  mode;

  modport source (output valid, linear_speed, angular_speed, mode, input ready);
  modport sink   (input valid, linear_speed, angular_speed, mode, output ready);
endinterface

// ===== design/gtg_step.sv =====
// One registered stage: a square-root digit step, a CORDIC vectoring step, or both.
module gtg_step #(
  parameter int STEP          = 0,
  parameter int CORDIC_STAGES = gtg_pkg::CordicStagesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  gtg_pkg::gtg_stage_t data_i,
  output logic               valid_o,
  output gtg_pkg::gtg_stage_t data_o
);
  import gtg_pkg::*;

  localparam bit DoSqrt  = (STEP < SqrtSteps);
  localparam bit DoRot   = (STEP < CORDIC_STAGES) && (STEP < AtanEntries);
  localparam int SqShift = DoSqrt ? (SqrtTop - 2 * STEP) : 0;
  localparam int RotSh   = DoRot ? STEP : 0;
  localparam logic [SqW-1:0] SqBit = SqW'(1) << SqShift;
  localparam logic signed [CzW-1:0] AtanStep = AtanTab[RotSh];

  logic [SqW:0]          trial;
  logic signed [CxW-1:0] xsh;
  logic signed [CxW-1:0] ysh;
  gtg_stage_t            nxt;
  logic                  valid_q;
  gtg_stage_t            data_q;

  assign trial = {1'b0, data_i.root} + {1'b0, SqBit};
  assign xsh   = data_i.cx >>> RotSh;
  assign ysh   = data_i.cy >>> RotSh;

  always_comb begin
    nxt = data_i;
    if (DoSqrt) begin
      if ({1'b0, data_i.rem} >= trial) begin
        nxt.rem  = data_i.rem - trial[SqW-1:0];
        nxt.root = (data_i.root >> 1) + SqBit;
      end else begin
        nxt.root = data_i.root >> 1;
      end
    end
    if (DoRot) begin
      // rotate toward the x axis
      if (data_i.cy > 0) begin
        nxt.cx = data_i.cx + ysh;
        nxt.cy = data_i.cy - xsh;
        nxt.cz = data_i.cz + AtanStep;
      end else begin
        nxt.cx = data_i.cx - ysh;
        nxt.cy = data_i.cy + xsh;
        nxt.cz = data_i.cz - AtanStep;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= nxt;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== design/go_to_goal_p_controller_unit.sv =====
// Go-to-goal proportional controller: pose in, speed command out.
// Pose to command: offset, square, seed, step chain, final and output registers.
// Throughput: one pose per cycle unless stalled; unrolled sqrt and CORDIC stages.
// A waiting command stalls every stage once the final stage 1 also holds a beat.
// Reset clears all valid bits and loads the register defaults; no clearing pass.
module go_to_goal_p_controller_unit #(
  parameter int CORDIC_STAGES = gtg_pkg::CordicStagesDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [gtg_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [gtg_pkg::CfgDataW-1:0] cfg_wdata_i,
  gtg_pose_if.sink                     pose_i,
  gtg_cmd_if.source                    cmd_o
);
  import gtg_pkg::*;

  localparam int Stages = (CORDIC_STAGES > SqrtSteps) ? CORDIC_STAGES : SqrtSteps;

  // Configuration registers
  logic [PosW-1:0]   tx_q, ty_q;
  logic [GainW-1:0]  gain_q;
  logic [SpeedW-1:0] max_q, dthr_q;
  logic [AngW-1:0]   athr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_q   <= TargetXRst;
      ty_q   <= TargetYRst;
      gain_q <= GainRst;
      max_q  <= MaxSpeedRst;
      dthr_q <= DistThrRst;
      athr_q <= AngThrRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgTargetX:  tx_q   <= cfg_wdata_i;
        CfgTargetY:  ty_q   <= cfg_wdata_i;
        CfgGain:     gain_q <= cfg_wdata_i;
        CfgMaxSpeed: max_q  <= cfg_wdata_i;
        CfgDistThr:  dthr_q <= cfg_wdata_i;
        CfgAngThr:   athr_q <= cfg_wdata_i[AngW-1:0];
        default: ;
      endcase
    end
  end

  // Flow control
  logic fin_v_q, out_v_q;
  logic en, out_load;

  assign out_load     = !out_v_q || cmd_o.ready;
  assign en           = out_load || !fin_v_q;
  assign pose_i.ready = en;

  // Stage 1: offsets to the goal
  logic                    s1_v_q;
  logic signed [DiffW-1:0] dx_q, dy_q;
  logic signed [AngW-1:0]  hd1_q;

  // Stage 2: squares and quadrant pre-rotation
  logic                    s2_v_q;
  logic signed [SqW-1:0]   sqx, sqy;
  logic [SqW-1:0]          sqx_q, sqy_q;
  logic signed [CxW-1:0]   xs, ys;
  logic signed [CxW-1:0]   px_d, py_d, px_q, py_q;
  logic signed [CzW-1:0]   pz_d, pz_q;
  logic signed [AngW-1:0]  hd2_q;

  // Stage 3 feeds the step chain
  logic                    s3_v_q;
  gtg_stage_t              s3_q;

  logic                    st_v [Stages+1];
  gtg_stage_t              st_d [Stages+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= pose_i.valid;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
    end
  end

  assign sqx = dx_q * dx_q;
  assign sqy = dy_q * dy_q;
  assign xs  = CxW'(dx_q) <<< PreShift;
  assign ys  = CxW'(dy_q) <<< PreShift;

  always_comb begin
    px_d = xs;
    py_d = ys;
    pz_d = '0;
    // bring the vector into the right half plane
    if (dx_q[DiffW-1]) begin
      if (!dy_q[DiffW-1]) begin
        px_d = ys;
        py_d = -xs;
        pz_d = AtanPiHalf;
      end else begin
        px_d = -ys;
        py_d = xs;
        pz_d = -AtanPiHalf;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx_q  <= {tx_q[PosW-1], tx_q} - {pose_i.pos_x[PosW-1], pose_i.pos_x};
      dy_q  <= {ty_q[PosW-1], ty_q} - {pose_i.pos_y[PosW-1], pose_i.pos_y};
      hd1_q <= pose_i.heading;

      sqx_q <= $unsigned(sqx);
      sqy_q <= $unsigned(sqy);
      px_q  <= px_d;
      py_q  <= py_d;
      pz_q  <= pz_d;
      hd2_q <= hd1_q;

      s3_q.rem  <= sqx_q + sqy_q;
      s3_q.root <= '0;
      s3_q.cx   <= px_q;
      s3_q.cy   <= py_q;
      s3_q.cz   <= pz_q;
      s3_q.hd   <= hd2_q;
    end
  end

  assign st_v[0] = s3_v_q;
  assign st_d[0] = s3_q;

  for (genvar k = 0; k < Stages; k++) begin : g_step
    gtg_step #(
      .STEP          (k),
      .CORDIC_STAGES (CORDIC_STAGES)
    ) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (st_v[k]),
      .data_i  (st_d[k]),
      .valid_o (st_v[k+1]),
      .data_o  (st_d[k+1])
    );
  end

  // Final stage 1: bearing error, arrival test, gain product
  gtg_stage_t              last;
  logic signed [CzW:0]     zr;
  logic signed [DiffW-1:0] brg;
  logic signed [AngW+2:0]  err;
  logic [AngW+2:0]         aerr_full;
  logic [DistW-1:0]        goal_dist;
  logic [AngW-1:0]         aerr_q;
  logic                    far_q;
  logic [GainW+DistW-1:0]  prod_q;

  assign last      = st_d[Stages];
  assign zr        = (CzW+1)'(last.cz) + (CzW+1)'(32768);
  assign brg       = DiffW'(zr >>> 16);
  assign err       = (AngW+3)'(brg) - (AngW+3)'(last.hd);
  assign aerr_full = err[AngW+2] ? $unsigned(-err) : $unsigned(err);
  assign goal_dist = last.root[DistW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_v_q <= 1'b0;
    end else if (en) begin
      fin_v_q <= st_v[Stages];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      aerr_q <= (|aerr_full[AngW+2:AngW]) ? {AngW{1'b1}} : aerr_full[AngW-1:0];
      far_q  <= goal_dist > {1'b0, dthr_q};
      prod_q <= (GainW+DistW)'(gain_q) * (GainW+DistW)'(goal_dist);
    end
  end

  // Final stage 2: mode select into the output register
  logic [GainW+DistW-13:0] lin_full;
  logic [SpeedW-1:0]       lin_q;
  logic [AngW-1:0]         ang_q;
  logic [ModeW-1:0]        mode_q;

  assign lin_full = prod_q[GainW+DistW-1:12];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_load) begin
      out_v_q <= fin_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      lin_q  <= '0;
      ang_q  <= '0;
      mode_q <= ModeStop;
      if (far_q) begin
        if (aerr_q > athr_q) begin
          ang_q  <= aerr_q;
          mode_q <= ModeRotate;
        end else begin
          lin_q  <= (lin_full > (GainW+DistW-12)'(max_q)) ? max_q : lin_full[SpeedW-1:0];
          mode_q <= ModeForward;
        end
      end
    end
  end

  assign cmd_o.valid         = out_v_q;
  assign cmd_o.linear_speed  = lin_q;
  assign cmd_o.angular_speed = ang_q;
  assign cmd_o.mode          = mode_q;

endmodule

// ===== design/gtg_checker.sv =====
// Port-level checks of the go-to-goal controller, bound to the top level.
module gtg_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         valid_i,
  input logic                         ready_i,
  input logic [gtg_pkg::SpeedW-1:0]   linear_speed_i,
  input logic [gtg_pkg::AngW-1:0]     angular_speed_i,
  input logic [gtg_pkg::ModeW-1:0]    mode_i
);
  import gtg_pkg::*;

  // A stalled command beat holds its payload
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> valid_i && $stable(linear_speed_i) &&
                            $stable(angular_speed_i) && $stable(mode_i))
    else $error("command beat changed while stalled");

  a_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && mode_i == ModeStop |-> linear_speed_i == '0 && angular_speed_i == '0)
    else $error("stop beat with nonzero speed");

  a_rotate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && mode_i == ModeRotate |-> linear_speed_i == '0 && angular_speed_i != '0)
    else $error("rotate beat with bad speeds");

  a_forward: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && mode_i == ModeForward |-> angular_speed_i == '0)
    else $error("forward beat with angular speed");

endmodule

bind go_to_goal_p_controller_unit gtg_checker u_gtg_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .valid_i         (cmd_o.valid),
  .ready_i         (cmd_o.ready),
  .linear_speed_i  (cmd_o.linear_speed),
  .angular_speed_i (cmd_o.angular_speed),
  .mode_i          (cmd_o.mode)
);

// ===== test/gtg_cmd_checker.sv =====
// Command checker: tracks register writes, predicts each command from its pose beat and compares.
`timescale 1ns / 100ps
module gtg_cmd_checker #(
  parameter int CORDIC_STAGES = gtg_pkg::CordicStagesDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [gtg_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [gtg_pkg::CfgDataW-1:0] cfg_wdata_i,
  gtg_pose_if                          pose_i,
  gtg_cmd_if                           cmd_i,
  output int                           errors_o,
  output int                           pending_o,
  output int                           stop_cnt_o,
  output int                           rotate_cnt_o,
  output int                           forward_cnt_o
);
  import gtg_pkg::*;

  localparam int ReportCap = 100;

  // atan(2^-i) in units of 2^-28 rad
  localparam longint ArcTanQ28 [24] = '{
    210828714, 124459457, 65760959, 33381290, 16755422, 8385879, 4193963,
    2097109, 1048571, 524287, 262144, 131072, 65536, 32768, 16384, 8192,
    4096, 2048, 1024, 512, 256, 128, 64, 32
  };
  localparam longint HalfPiQ28 = 421657428;

  typedef struct packed {
    logic [SpeedW-1:0] lin;
    logic [AngW-1:0]   ang;
    logic [ModeW-1:0]  mode;
  } steer_cmd_t;

  logic signed [PosW-1:0] goal_x, goal_y;
  logic [GainW-1:0]       gain_q;
  logic [SpeedW-1:0]      speed_cap;
  logic [SpeedW-1:0]      arrive_dist;
  logic [AngW-1:0]        turn_thr;
  steer_cmd_t             cmd_due_q [$];

  function automatic steer_cmd_t steer_cmd(input logic signed [PosW-1:0] px,
                                           input logic signed [PosW-1:0] py,
                                           input logic signed [AngW-1:0] hd);
    longint          dx, dy, cx, cy, cz, nx, bearing_q12, err;
    longint unsigned rem, root, probe, goal_dist, aerr, lin;
    steer_cmd_t      c;
    dx = longint'(goal_x) - longint'(px);
    dy = longint'(goal_y) - longint'(py);

    // floor square root of dx^2 + dy^2, one result bit per pass
    rem   = dx * dx + dy * dy;
    root  = 0;
    probe = 64'h4000_0000_0000_0000;
    while (probe > rem) probe >>= 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem  = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root >>= 1;
      end
      probe >>= 2;
    end
    goal_dist = root;

    bearing_q12 = 0;
    if (dx != 0 || dy != 0) begin
      cx = dx * 16384;
      cy = dy * 16384;
      cz = 0;
      // rotate the left half plane by a quarter turn first
      if (cx < 0) begin
        nx = cx;
        if (cy >= 0) begin
          cx = cy;
          cy = -nx;
          cz = HalfPiQ28;
        end else begin
          cx = -cy;
          cy = nx;
          cz = -HalfPiQ28;
        end
      end
      for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
        if (cy > 0) begin
          nx = cx + (cy >>> i);
          cy = cy - (cx >>> i);
          cz = cz + ArcTanQ28[i];
        end else begin
          nx = cx - (cy >>> i);
          cy = cy + (cx >>> i);
          cz = cz - ArcTanQ28[i];
        end
        cx = nx;
      end
      bearing_q12 = (cz + 32768) >>> 16;
    end

    err  = bearing_q12 - longint'(hd);
    aerr = (err < 0) ? -err : err;
    if (aerr > 32767) aerr = 32767;

    c      = '0;
    c.mode = ModeStop;
    if (goal_dist > arrive_dist) begin
      if (aerr > turn_thr) begin
        c.ang  = aerr[AngW-1:0];
        c.mode = ModeRotate;
      end else begin
        lin = (goal_dist * gain_q) >> 12;
        if (lin > speed_cap) lin = speed_cap;
        c.lin  = lin[SpeedW-1:0];
        c.mode = ModeForward;
      end
    end
    return c;
  endfunction

  task automatic flag_mismatch(input string field, input logic [15:0] want,
                               input logic [15:0] got);
    if (errors_o < ReportCap) begin
      $error("%s: expected %0d, got %0d", field, want, got);
    end else if (errors_o == ReportCap) begin
      $display("further mismatches are counted without a report");
    end
    errors_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    steer_cmd_t want;
    if (!rst_ni) begin
      goal_x      <= TargetXRst;
      goal_y      <= TargetYRst;
      gain_q      <= GainRst;
      speed_cap   <= MaxSpeedRst;
      arrive_dist <= DistThrRst;
      turn_thr    <= AngThrRst;
      cmd_due_q.delete();
      pending_o   <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgTargetX:  goal_x      <= cfg_wdata_i;
          CfgTargetY:  goal_y      <= cfg_wdata_i;
          CfgGain:     gain_q      <= cfg_wdata_i;
          CfgMaxSpeed: speed_cap   <= cfg_wdata_i;
          CfgDistThr:  arrive_dist <= cfg_wdata_i;
          CfgAngThr:   turn_thr    <= cfg_wdata_i[AngW-1:0];
          default: ;
        endcase
      end

      // check the command beat before queuing this cycle's pose
      if (cmd_i.valid && cmd_i.ready) begin
        if (cmd_due_q.size() == 0) begin
          flag_mismatch("command with no pose pending, mode", '0, 16'(cmd_i.mode));
        end else begin
          want = cmd_due_q.pop_front();
          if (cmd_i.linear_speed !== want.lin)
            flag_mismatch("linear_speed", want.lin, cmd_i.linear_speed);
          if (cmd_i.angular_speed !== want.ang)
            flag_mismatch("angular_speed", 16'(want.ang), 16'(cmd_i.angular_speed));
          if (cmd_i.mode !== want.mode)
            flag_mismatch("mode", 16'(want.mode), 16'(cmd_i.mode));
          case (want.mode)
            ModeStop:   stop_cnt_o++;
            ModeRotate: rotate_cnt_o++;
            default:    forward_cnt_o++;
          endcase
        end
      end

      if (pose_i.valid && pose_i.ready)
        cmd_due_q.push_back(steer_cmd(pose_i.pos_x, pose_i.pos_y, pose_i.heading));
      pending_o <= cmd_due_q.size();
    end
  end

endmodule

// ===== test/tb.sv =====
// Top of the go-to-goal controller bench: clock, reset, register setup, pose stimulus, verdict.
`timescale 1ns / 100ps
module tb;
  import gtg_pkg::*;

  localparam int Stages       = CordicStagesDef;
  localparam int Latency      = ((Stages > SqrtSteps) ? Stages : SqrtSteps) + 5;
  localparam int HoldCycles   = 300;
  localparam int CycleLimit   = 400000;
  localparam int DirectedLen  = 20;
  localparam int EdgeSetups   = 3;
  localparam int EdgePoses    = 40;
  localparam int RandSetups   = 8;
  localparam int RandPoses    = 80;
  localparam int CfgWrites    = 8;
  localparam logic [CfgIdxW-1:0] CfgNoReg   = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgNoRegHi = 3'd7;

  typedef struct packed {
    logic signed [PosW-1:0] tx;
    logic signed [PosW-1:0] ty;
    logic [GainW-1:0]       gain;
    logic [SpeedW-1:0]      vmax;
    logic [SpeedW-1:0]      dthr;
    logic [AngW-1:0]        athr;
  } goal_cfg_t;

  typedef struct packed {
    logic signed [PosW-1:0] x;
    logic signed [PosW-1:0] y;
    logic signed [AngW-1:0] hd;
  } pose_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;
  logic                hold_req;
  int                  errors, pending, n_stop, n_rot, n_fwd;
  int                  cycles;
  int                  poses_sent;
  int                  setups_used;
  int                  burst_left;
  goal_cfg_t           cur;

  gtg_pose_if pose_if ();
  gtg_cmd_if  cmd_if ();

  go_to_goal_p_controller_unit #(
    .CORDIC_STAGES(Stages)
  ) uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .pose_i     (pose_if),
    .cmd_o      (cmd_if)
  );

  gtg_cmd_checker #(
    .CORDIC_STAGES(Stages)
  ) cmd_chk (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .pose_i       (pose_if),
    .cmd_i        (cmd_if),
    .errors_o     (errors),
    .pending_o    (pending),
    .stop_cnt_o   (n_stop),
    .rotate_cnt_o (n_rot),
    .forward_cnt_o(n_fwd)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("timeout after %0d cycles with %0d commands still due", cycles, pending);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Command side: segments of random ready density, plus a long hold on request
  initial begin
    int seg_left;
    int pct;
    seg_left = 0;
    pct      = 100;
    cmd_if.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_req) begin
        hold_req     <= 1'b0;
        cmd_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(1, 64);
          case ($urandom_range(0, 3))
            0:       pct = 100;
            1:       pct = 75;
            2:       pct = 50;
            default: pct = 20;
          endcase
        end
        cmd_if.ready <= ($urandom_range(0, 99) < pct);
        seg_left--;
        @(posedge clk);
      end
    end
  end

  function automatic goal_cfg_t rand_goal_cfg();
    goal_cfg_t c;
    c.tx   = PosW'($urandom);
    c.ty   = PosW'($urandom);
    c.gain = ($urandom_range(0, 3) == 0) ? GainW'($urandom) : GainW'($urandom_range(0, 16384));
    c.vmax = ($urandom_range(0, 3) == 0) ? SpeedW'($urandom) : SpeedW'($urandom_range(64, 2048));
    c.dthr = ($urandom_range(0, 4) == 0) ? SpeedW'($urandom) : SpeedW'($urandom_range(0, 300));
    c.athr = ($urandom_range(0, 4) == 0) ? AngW'($urandom) : AngW'($urandom_range(0, 4096));
    return c;
  endfunction

  // Mostly poses near the goal, headings aimed near the bearing half the time
  function automatic pose_t rand_pose();
    pose_t p;
    int    pick, spread, ox, oy, w, aim;
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      p.x = cur.tx;
      p.y = cur.ty;
    end else if (pick < 20) begin
      p.x = PosW'($urandom);
      p.y = PosW'($urandom);
    end else begin
      spread = 8 << (3 * $urandom_range(0, 3));
      ox     = int'($urandom_range(0, 2 * spread)) - spread;
      oy     = int'($urandom_range(0, 2 * spread)) - spread;
      p.x    = PosW'(int'(cur.tx) + ox);
      p.y    = PosW'(int'(cur.ty) + oy);
    end
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      w   = (int'(cur.athr) > 4000) ? 4096 : int'(cur.athr) + 96;
      aim = $rtoi($atan2(real'(int'(cur.ty) - int'(p.y)),
                         real'(int'(cur.tx) - int'(p.x))) * 4096.0);
      aim = aim + int'($urandom_range(0, 2 * w)) - w;
      if (aim > 16383) aim = 16383;
      if (aim < -16384) aim = -16384;
      p.hd = AngW'(aim);
    end else if (pick < 85) begin
      p.hd = AngW'(int'($urandom_range(0, 25736)) - 12868);
    end else begin
      p.hd = AngW'($urandom);
    end
    return p;
  endfunction

  task automatic apply_goal_cfg(input goal_cfg_t c);
    logic [CfgIdxW-1:0]  idx [CfgWrites];
    logic [CfgDataW-1:0] val [CfgWrites];
    idx = '{CfgTargetX, CfgTargetY, CfgGain, CfgMaxSpeed, CfgDistThr, CfgAngThr,
            CfgNoReg, CfgNoRegHi};
    // junk in the spare top bit of the angle limit and in the unused slots
    val = '{c.tx, c.ty, c.gain, c.vmax, c.dthr, {1'($urandom), c.athr},
            CfgDataW'($urandom), CfgDataW'($urandom)};
    for (int k = 0; k < CfgWrites; k++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= idx[k];
      cfg_wdata <= val[k];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    cur    = c;
    setups_used++;
  endtask

  task automatic send_pose(input pose_t p);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : $urandom_range(0, 2);
      if (gap > 0) begin
        pose_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
    end
    pose_if.valid   <= 1'b1;
    pose_if.pos_x   <= p.x;
    pose_if.pos_y   <= p.y;
    pose_if.heading <= p.hd;
    do @(posedge clk); while (!pose_if.ready);
    burst_left--;
    poses_sent++;
  endtask

  // Hold the pose side until every command due has arrived
  task automatic drain();
    pose_if.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    pose_t     seq [DirectedLen];
    goal_cfg_t edge_cfg [EdgeSetups];
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_idx         <= '0;
    cfg_wdata       <= '0;
    hold_req        <= 1'b0;
    pose_if.valid   <= 1'b0;
    pose_if.pos_x   <= '0;
    pose_if.pos_y   <= '0;
    pose_if.heading <= '0;
    cur         = '{TargetXRst, TargetYRst, GainRst, MaxSpeedRst, DistThrRst, AngThrRst};
    burst_left  = 0;
    poses_sent  = 0;
    setups_used = 1;

    // Against the reset goal (1.0, 1.0)
    seq = '{
      '{256, 256, 0},                 // on the goal
      '{230, 256, 0},                 // exactly at the arrival distance
      '{229, 256, 0},                 // just past it
      '{0, 256, 819}, '{0, 256, -819}, '{0, 256, 820}, '{0, 256, -820},
      '{0, 0, 3217},                  // aimed, forward below the cap
      '{0, 0, 12868},                 // facing away, turn in place
      '{-32768, -32768, -12868}, '{32767, 32767, 12868},
      '{32767, -32768, 0}, '{-32768, 32767, 0},
      '{512, 256, 0}, '{512, 0, 0}, '{512, 512, 0},   // goal behind, all sides
      '{-2560, -2560, 3217},          // far and aimed, speed capped
      '{0, 256, -16384}, '{0, 256, 16383},            // heading field extremes
      '{256, 0, 6434}                 // goal straight along +y
    };
    edge_cfg = '{
      '{16'sd0, 16'sd0, 16'hFFFF, 16'hFFFF, 16'd0, 15'h7FFF},
      '{-16'sd32768, 16'sd32767, 16'd0, 16'd0, 16'hFFFF, 15'd0},
      '{16'sd32767, -16'sd32768, 16'd1, 16'd0, 16'd1, 15'd16384}
    };

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (seq[k]) send_pose(seq[k]);
    drain();

    for (int e = 0; e < EdgeSetups; e++) begin
      apply_goal_cfg(edge_cfg[e]);
      if (e == 0) hold_req <= 1'b1;
      repeat (EdgePoses) send_pose(rand_pose());
      drain();
    end

    for (int r = 0; r < RandSetups; r++) begin
      apply_goal_cfg(rand_goal_cfg());
      if (r == 3) hold_req <= 1'b1;
      repeat (RandPoses) send_pose(rand_pose());
      drain();
    end

    repeat (2 * Latency) @(posedge clk);
    $display("Sent %0d poses under %0d register setups, incl. long output holds and drains",
             poses_sent, setups_used);
    $display("Commands checked: %0d stopped, %0d turning in place, %0d driving forward",
             n_stop, n_rot, n_fwd);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
